// ----- hw/rtl/cdm_pkg.sv -----
// Shared widths, codes and types of the callback deadline monitor.
package cdm_pkg;

    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int TICK_W   = 48;
    localparam int SUM_W    = 64;
    localparam int CNT_W    = 32;
    localparam int FREQ_W   = 32;
    localparam int RATE_W   = 20;
    localparam int FRAMES_W = 16;
    localparam int TAG_W    = 16;
    localparam int PROD_W   = RATE_W + FRAMES_W;
    localparam int ITER_W   = 6;

    localparam logic [RATE_W-1:0] NEAR_DIVISOR = RATE_W'(10);

    typedef enum logic [1:0] {
        REG_TICK_FREQ   = 2'd0,
        REG_SAMPLE_RATE = 2'd1,
        REG_BUF_FRAMES  = 2'd2,
        REG_CONFIG_TAG  = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CLS_ON_TIME = 2'd0,
        CLS_NEAR    = 2'd1,
        CLS_OVERRUN = 2'd2,
        CLS_NONE    = 2'd3
    } t_timing_class;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
    } t_div_ctl;

endpackage

// ----- hw/rtl/cdm_div.sv -----
// Bit-serial restoring divider shared by every division of the monitor.
module cdm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cdm_pkg::t_div_ctl           i_ctl,
    input  logic [cdm_pkg::TICK_W-1:0]  i_dividend,
    input  logic [cdm_pkg::RATE_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [cdm_pkg::TICK_W-1:0]  o_quotient,
    output logic [cdm_pkg::RATE_W-1:0]  o_remainder
);
    import cdm_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [ITER_W-1:0]   r_count;
    logic [TICK_W-1:0]   r_dvd;
    logic [RATE_W-1:0]   r_rem;
    logic [RATE_W-1:0]   r_dvs;

    logic [RATE_W:0]     w_rem_sh;
    logic                w_ge;
    logic [RATE_W:0]     w_rem_sub;

    // The dividend arrives left-aligned, so each step takes the top bit.
    assign w_rem_sh  = {r_rem, r_dvd[TICK_W-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_dvs};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_count <= i_ctl.iters;
                r_dvd   <= i_dividend;
                r_rem   <= '0;
                r_dvs   <= i_divisor;
            end else if (r_busy) begin
                r_dvd   <= {r_dvd[TICK_W-2:0], w_ge};
                r_rem   <= w_ge ? w_rem_sub[RATE_W-1:0] : w_rem_sh[RATE_W-1:0];
                r_count <= r_count - ITER_W'(1);
                if (r_count == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;

endmodule

// ----- hw/rtl/callback_deadline_monitor.sv -----
// Top level of the callback deadline monitor: registers, sequencer and counters.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  input    | in        | i_in_valid / o_in_stall | i_elapsed
//  output   | out       | o_out_valid/i_out_stall | o_accepted ... o_tag_echo
//  config   | in        | psel penable pwrite     | paddr pwdata prdata pready
//
//  Each result is computed by the one-bit-per-cycle divider, which runs two passes:
//  32 steps for f/sr and 36 for the fractional part. The near-overrun test forms
//  the slack in S_GAP and compares ten times the slack with the deadline in S_CMP.
//  With a zero sample rate or frame count the sequencer goes from S_IDLE straight to
//  S_FINISH. The next item can be taken in the cycle after a result is registered,
//  even while it waits under i_out_stall; each stalled cycle delays the next result.
//  Reset is synchronous and clears the registers, counters and control state.
module callback_deadline_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cdm_pkg::ADDR_W-1:0]    paddr,
    input  logic [cdm_pkg::DATA_W-1:0]    pwdata,
    output logic [cdm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cdm_pkg::TICK_W-1:0]    i_elapsed,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_accepted,
    output logic [1:0]                    o_timing_class,
    output logic [cdm_pkg::CNT_W-1:0]     o_callbacks_seen,
    output logic [cdm_pkg::TICK_W-1:0]    o_frames_seen,
    output logic [cdm_pkg::SUM_W-1:0]     o_ticks_total,
    output logic [cdm_pkg::TICK_W-1:0]    o_ticks_worst,
    output logic [cdm_pkg::CNT_W-1:0]     o_overrun_total,
    output logic [cdm_pkg::CNT_W-1:0]     o_near_total,
    output logic [cdm_pkg::TICK_W-1:0]    o_deadline_ticks,
    output logic [cdm_pkg::TAG_W-1:0]     o_tag_echo
);
    import cdm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_F,
        S_MUL,
        S_DIV_R,
        S_GAP,
        S_CMP,
        S_FINISH
    } t_state;

    t_state              r_state;

    logic [FREQ_W-1:0]   r_tick_freq;
    logic [RATE_W-1:0]   r_sample_rate;
    logic [FRAMES_W-1:0] r_buf_frames;
    logic [TAG_W-1:0]    r_config_tag;

    logic [CNT_W-1:0]    r_callbacks;
    logic [TICK_W-1:0]   r_frames;
    logic [SUM_W-1:0]    r_ticks;
    logic [TICK_W-1:0]   r_worst;
    logic [CNT_W-1:0]    r_overruns;
    logic [CNT_W-1:0]    r_nears;
    logic [TAG_W-1:0]    r_tag;

    logic [TICK_W-1:0]   r_elapsed;
    logic [TICK_W-1:0]   r_whole;
    logic [PROD_W-1:0]   r_part_prod;
    logic [TICK_W-1:0]   r_deadline;
    logic [TICK_W-1:0]   r_gap;
    logic                r_near_hit;

    logic                r_out_valid;
    logic                r_out_accepted;
    t_timing_class       r_out_class;
    logic [TICK_W-1:0]   r_out_deadline;

    t_div_ctl            r_div_ctl;
    logic [TICK_W-1:0]   r_div_a;

    logic                w_div_done;
    logic [TICK_W-1:0]   w_quot;
    logic [RATE_W-1:0]   w_rem;

    logic                w_cfg_write;
    logic                w_in_xfer;
    logic                w_out_free;
    logic                w_take;
    logic                w_has_dl;
    logic                w_over;
    logic                w_near;
    logic [TICK_W+3:0]   w_gap_x10;
    t_timing_class       w_class;

    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_take      = (r_tick_freq != '0) && (r_sample_rate != '0) &&
                         (r_buf_frames != '0);
    assign w_has_dl    = w_take && (r_deadline != '0);
    assign w_over      = w_has_dl && (r_elapsed >= r_deadline);
    assign w_near      = w_has_dl && !w_over && r_near_hit;
    assign w_gap_x10   = {1'b0, r_gap, 3'b000} + {3'b000, r_gap, 1'b0};

    always_comb begin
        if (!w_has_dl) begin
            w_class = CLS_NONE;
        end else if (w_over) begin
            w_class = CLS_OVERRUN;
        end else if (w_near) begin
            w_class = CLS_NEAR;
        end else begin
            w_class = CLS_ON_TIME;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_freq   <= '0;
            r_sample_rate <= '0;
            r_buf_frames  <= '0;
            r_config_tag  <= '0;
        end else if (w_cfg_write) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_TICK_FREQ:   r_tick_freq   <= pwdata[FREQ_W-1:0];
                REG_SAMPLE_RATE: r_sample_rate <= pwdata[RATE_W-1:0];
                REG_BUF_FRAMES:  r_buf_frames  <= pwdata[FRAMES_W-1:0];
                REG_CONFIG_TAG:  r_config_tag  <= pwdata[TAG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_TICK_FREQ:   prdata = DATA_W'(r_tick_freq);
            REG_SAMPLE_RATE: prdata = DATA_W'(r_sample_rate);
            REG_BUF_FRAMES:  prdata = DATA_W'(r_buf_frames);
            REG_CONFIG_TAG:  prdata = DATA_W'(r_config_tag);
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    cdm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_div_ctl),
        .i_dividend  (r_div_a),
        .i_divisor   (r_sample_rate),
        .o_done      (w_div_done),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_ctl   <= '0;
            r_out_valid <= 1'b0;
            r_callbacks <= '0;
            r_frames    <= '0;
            r_ticks     <= '0;
            r_worst     <= '0;
            r_overruns  <= '0;
            r_nears     <= '0;
            r_tag       <= '0;
        end else begin
            if ((r_state == S_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_elapsed <= i_elapsed;
                        if ((r_sample_rate != '0) && (r_buf_frames != '0)) begin
                            r_div_a   <= {r_tick_freq, {(TICK_W - FREQ_W){1'b0}}};
                            r_div_ctl <= '{start: 1'b1, iters: ITER_W'(FREQ_W)};
                            r_state   <= S_DIV_F;
                        end else begin
                            r_deadline <= '0;
                            r_state    <= S_FINISH;
                        end
                    end
                end
                S_DIV_F: begin
                    r_div_ctl.start <= 1'b0;
                    if (w_div_done) begin
                        r_whole     <= TICK_W'(w_quot[FREQ_W-1:0]) * TICK_W'(r_buf_frames);
                        r_part_prod <= PROD_W'(w_rem) * PROD_W'(r_buf_frames);
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_div_a   <= {r_part_prod, {(TICK_W - PROD_W){1'b0}}};
                    r_div_ctl <= '{start: 1'b1, iters: ITER_W'(PROD_W)};
                    r_state   <= S_DIV_R;
                end
                S_DIV_R: begin
                    r_div_ctl.start <= 1'b0;
                    if (w_div_done) begin
                        r_deadline <= r_whole + w_quot;
                        r_state    <= S_GAP;
                    end
                end
                S_GAP: begin
                    r_gap   <= r_deadline - r_elapsed;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_near_hit <= w_gap_x10 <= {4'b0000, r_deadline};
                    r_state    <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        if (w_take) begin
                            r_callbacks <= r_callbacks + CNT_W'(1);
                            r_frames    <= r_frames + TICK_W'(r_buf_frames);
                            r_ticks     <= r_ticks + SUM_W'(r_elapsed);
                            if (r_elapsed > r_worst) begin
                                r_worst <= r_elapsed;
                            end
                            if (w_over) begin
                                r_overruns <= r_overruns + CNT_W'(1);
                            end
                            if (w_near) begin
                                r_nears <= r_nears + CNT_W'(1);
                            end
                            r_tag <= r_config_tag;
                        end
                        r_out_accepted <= w_take;
                        r_out_class    <= w_class;
                        r_out_deadline <= r_deadline;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_out_accepted;
    assign o_timing_class   = r_out_class;
    assign o_callbacks_seen = r_callbacks;
    assign o_frames_seen    = r_frames;
    assign o_ticks_total    = r_ticks;
    assign o_ticks_worst    = r_worst;
    assign o_overrun_total  = r_overruns;
    assign o_near_total     = r_nears;
    assign o_deadline_ticks = r_out_deadline;
    assign o_tag_echo       = r_tag;

endmodule

// ----- hw/rtl/cdm_checker.sv -----
// Port-level assertions for the callback deadline monitor and their bind.
module cdm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          o_accepted,
    input  logic [1:0]                    o_timing_class,
    input  logic [cdm_pkg::CNT_W-1:0]     o_callbacks_seen,
    input  logic [cdm_pkg::TICK_W-1:0]    o_deadline_ticks
);
    import cdm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_callbacks_seen))
        else $error("Stalled result transfer changed.");

    a_ignored_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |-> o_timing_class == CLS_NONE)
        else $error("Ignored item carries a timing class.");

    a_no_deadline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_deadline_ticks == '0) |-> o_timing_class == CLS_NONE)
        else $error("Item without a deadline was classified.");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input not stalled while an item is in work.");

endmodule

bind callback_deadline_monitor cdm_checker u_cdm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_accepted       (o_accepted),
    .o_timing_class   (o_timing_class),
    .o_callbacks_seen (o_callbacks_seen),
    .o_deadline_ticks (o_deadline_ticks)
);
